// ----- rtl/fecu_pkg.sv -----
// Shared constants and types for the fire effect cell update block.
`timescale 1ns / 1ps
package fecu_pkg;

   // Grid geometry
   localparam int COLS   = 128;
   localparam int ROWS   = 128;
   localparam int CELLS  = COLS * ROWS;
   localparam int COL_W  = $clog2(COLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);

   // Port field widths
   localparam int FUNC_W  = 2;
   localparam int FIELD_W = 7;
   localparam int VAL_W   = 8;
   localparam int TAB_N   = 1 << FIELD_W;

   // Function codes on the request channel
   localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

   // Averaging arithmetic: (sum * 32) / 129 via reciprocal and one correction
   localparam int SUM_W       = 10;
   localparam int SCALE_SHIFT = 5;
   localparam int PROD_W      = SUM_W + SCALE_SHIFT;
   localparam int DIV_SHIFT   = 7;
   localparam int DIVISOR     = (1 << DIV_SHIFT) + 1;
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / DIVISOR;
   localparam int MULT_W      = 2 * PROD_W;

   // Queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_COMPUTE,
      KIND_READ
   } kind_type;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      kind_type               kind;
      addr_type               here;
      addr_type [3:0]         nb;
      logic [VAL_W-1:0]       value;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } q_wr_type;

   typedef logic [COL_W-1:0] col_tab_type [TAB_N];
   typedef logic [ROW_W-1:0] row_tab_type [TAB_N];

   function automatic col_tab_type col_tab_build();
      col_tab_type t;
      for (int i = 0; i < TAB_N; i++) begin
         t[i] = COL_W'(i % COLS);
      end
      return t;
   endfunction

   function automatic row_tab_type row_tab_build();
      row_tab_type t;
      for (int i = 0; i < TAB_N; i++) begin
         t[i] = ROW_W'(i % ROWS);
      end
      return t;
   endfunction

   // Reduction of the port's column and row fields into the grid
   localparam col_tab_type COL_TAB = col_tab_build();
   localparam row_tab_type ROW_TAB = row_tab_build();

endpackage

// ----- rtl/fecu_front.sv -----
// Front end: takes request transactions, decodes them and forms cell addresses.
`timescale 1ns / 1ps
module fecu_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fecu_pkg::FUNC_W-1:0]   req_func,
   input  logic [fecu_pkg::FIELD_W-1:0]  req_col,
   input  logic [fecu_pkg::FIELD_W-1:0]  req_row,
   input  logic [fecu_pkg::VAL_W-1:0]    req_value,
   input  logic                          q_full,
   input  logic                          clearing,
   output fecu_pkg::q_wr_type            q_wr
);
   import fecu_pkg::*;

   logic [COL_W-1:0] col_r, col_left, col_right;
   logic [ROW_W-1:0] row_r, row_1, row_2;
   kind_type         kind;

   function automatic logic [COL_W-1:0] col_inc(input logic [COL_W-1:0] c);
      return (c == COL_W'(COLS - 1)) ? '0 : c + 1'b1;
   endfunction

   function automatic logic [COL_W-1:0] col_dec(input logic [COL_W-1:0] c);
      return (c == '0) ? COL_W'(COLS - 1) : c - 1'b1;
   endfunction

   function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
      return (r == ROW_W'(ROWS - 1)) ? '0 : r + 1'b1;
   endfunction

   function automatic addr_type addr_of(input logic [ROW_W-1:0] r,
                                        input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
   endfunction

   assign col_r     = COL_TAB[req_col];
   assign row_r     = ROW_TAB[req_row];
   assign col_left  = col_dec(col_r);
   assign col_right = col_inc(col_r);
   assign row_1     = row_inc(row_r);
   assign row_2     = row_inc(row_1);

   always_comb begin
      case (req_func)
         FUNC_WRITE:   kind = KIND_WRITE;
         FUNC_COMPUTE: kind = KIND_COMPUTE;
         FUNC_READ:    kind = KIND_READ;
         default:      kind = KIND_READ; // spare code behaves as a read
      endcase
   end

   assign req_ready = !q_full && !clearing;

   always_comb begin
      q_wr.valid     = req_valid && req_ready;
      q_wr.job.kind  = kind;
      q_wr.job.here  = addr_of(row_r, col_r);
      q_wr.job.nb[0] = addr_of(row_1, col_left);
      q_wr.job.nb[1] = addr_of(row_1, col_r);
      q_wr.job.nb[2] = addr_of(row_1, col_right);
      q_wr.job.nb[3] = addr_of(row_2, col_r);
      q_wr.job.value = req_value;
   end

endmodule

// ----- rtl/fecu_queue.sv -----
// Short job queue between the front end and the cell engine.
`timescale 1ns / 1ps
module fecu_queue (
   input  logic                clock,
   input  logic                reset,
   input  fecu_pkg::q_wr_type  q_wr,
   output logic                q_full,
   input  logic                q_pop,
   output logic                q_valid,
   output fecu_pkg::job_type   q_head
);
   import fecu_pkg::*;

   job_type             entries [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign q_full  = (count_ff == QCNT_W'(QDEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = entries[rd_ptr_ff];
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = q_wr.valid ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case ({q_wr.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_wr.valid) begin
         entries[wr_ptr_ff] <= q_wr.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/fecu_back.sv -----
// Cell engine: grid memory, clearing sweep, neighbour gather, averaging and response register.
`timescale 1ns / 1ps
module fecu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  fecu_pkg::job_type           q_head,
   output logic                        q_pop,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [fecu_pkg::VAL_W-1:0]  rsp_intensity
);
   import fecu_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_RDATA,
      ST_GATHER,
      ST_MUL,
      ST_FIX,
      ST_DONE
   } state_type;

   localparam logic [2:0] LAST_IDX = 3'd4;

   state_type          state_ff, state_in;
   addr_type           clr_addr_ff, clr_addr_in;
   job_type            job_ff, job_in;
   logic [2:0]         idx_ff, idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [MULT_W-1:0]  prod_ff, prod_in;
   logic [VAL_W-1:0]   res_ff, res_in;
   logic               out_valid_ff, out_valid_in;
   logic [VAL_W-1:0]   out_data_ff, out_data_in;

   logic [VAL_W-1:0]   mem [CELLS];
   logic [VAL_W-1:0]   mem_rdata_ff;
   logic               mem_we;
   addr_type           mem_addr;
   logic [VAL_W-1:0]   mem_wdata;

   logic [PROD_W-1:0]  scaled;
   logic [VAL_W-1:0]   q_est;
   logic [PROD_W-1:0]  q_back;
   logic [PROD_W-1:0]  rem;
   logic               out_free;

   assign scaled   = {sum_ff, {SCALE_SHIFT{1'b0}}};
   assign q_est    = prod_ff[RECIP_SHIFT +: VAL_W];
   assign q_back   = (PROD_W'(q_est) << DIV_SHIFT) + PROD_W'(q_est);
   assign rem      = scaled - q_back;
   assign out_free = !out_valid_ff || rsp_ready;

   assign clearing      = (state_ff == ST_CLEAR);
   assign rsp_valid     = out_valid_ff;
   assign rsp_intensity = out_data_ff;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_data_in  = out_data_ff;
      mem_we       = 1'b0;
      mem_addr     = job_ff.here;
      mem_wdata    = res_ff;
      q_pop        = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               job_in = q_head;
               sum_in = '0;
               idx_in = '0;
               res_in = q_head.value;
               case (q_head.kind)
                  KIND_WRITE:   state_in = ST_DONE;
                  KIND_COMPUTE: state_in = ST_GATHER;
                  default:      state_in = ST_READ;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            res_in   = mem_rdata_ff;
            state_in = ST_DONE;
         end
         ST_GATHER: begin
            // read data comes back in the cycle after its address
            mem_addr = job_ff.nb[idx_ff[1:0]];
            if (idx_ff != '0) begin
               sum_in = sum_ff + SUM_W'(mem_rdata_ff);
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_MUL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_MUL: begin
            prod_in  = MULT_W'(scaled) * MULT_W'(RECIP_MUL);
            state_in = ST_FIX;
         end
         ST_FIX: begin
            // reciprocal is rounded down, so the estimate is short by at most one
            res_in   = (rem >= PROD_W'(DIVISOR)) ? q_est + 1'b1 : q_est;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               mem_we       = (job_ff.kind != KIND_READ);
               out_valid_in = 1'b1;
               out_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff      <= job_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

endmodule

// ----- rtl/fire_effect_cell_update_core.sv -----
// Top level of the fire effect cell update block.
// After reset the block sweeps the whole cell memory to zero, one cell per cycle, and holds
// req_ready low until the sweep is done. Each request gives exactly one response, in order. The
// engine works on one transaction at a time. A compute is the longest transaction, as it makes the
// four neighbour reads through the single-port cell memory plus the reciprocal multiply and its
// correction. A two-entry queue in front of the engine, the transaction parked in the engine and the
// response register let up to four transactions be held while the response side stalls.
`timescale 1ns / 1ps
module fire_effect_cell_update_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fecu_pkg::FUNC_W-1:0]   req_func,
   input  logic [fecu_pkg::FIELD_W-1:0]  req_col,
   input  logic [fecu_pkg::FIELD_W-1:0]  req_row,
   input  logic [fecu_pkg::VAL_W-1:0]    req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fecu_pkg::VAL_W-1:0]    rsp_intensity
);
   import fecu_pkg::*;

   q_wr_type q_wr;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   job_type  q_head;
   logic     clearing;

   fecu_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_col   (req_col),
      .req_row   (req_row),
      .req_value (req_value),
      .q_full    (q_full),
      .clearing  (clearing),
      .q_wr      (q_wr)
   );

   fecu_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_wr    (q_wr),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_head  (q_head)
   );

   fecu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_intensity (rsp_intensity)
   );

endmodule

// ----- rtl/fecu_checker.sv -----
// Port-level checks for the fire effect cell update block, bound to the top level.
`timescale 1ns / 1ps
module fecu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [fecu_pkg::FUNC_W-1:0]   req_func,
   input logic [fecu_pkg::FIELD_W-1:0]  req_col,
   input logic [fecu_pkg::FIELD_W-1:0]  req_row,
   input logic [fecu_pkg::VAL_W-1:0]    req_value,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fecu_pkg::VAL_W-1:0]    rsp_intensity
);

   // no response can be pending straight after reset
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // memory sweep keeps the request side closed straight after reset
   a_sweep_blocks_req: assert property (@(posedge clock) reset |=> !req_ready ##1 !req_ready)
      else $error("request accepted during memory sweep");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_intensity))
      else $error("stalled response dropped or changed");

endmodule

bind fire_effect_cell_update_core fecu_checker u_fecu_checker (.*);

// ----- tb/sv/fecu_grid_check.sv -----
// Checker for the fire effect cell update block: grid predictor and response compare.
`timescale 1ns / 1ps
module fecu_grid_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [fecu_pkg::FUNC_W-1:0]   req_func,
   input  logic [fecu_pkg::FIELD_W-1:0]  req_col,
   input  logic [fecu_pkg::FIELD_W-1:0]  req_row,
   input  logic [fecu_pkg::VAL_W-1:0]    req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [fecu_pkg::VAL_W-1:0]    rsp_intensity,
   output int unsigned                   fail_count,
   output int                            pending
);
   import fecu_pkg::*;

   localparam int HEAT_GAIN = 32;
   localparam int HEAT_DIV  = 129;

   logic [VAL_W-1:0] heat [CELLS];
   logic [VAL_W-1:0] intensity_q [$];
   logic [VAL_W-1:0] want;
   int unsigned      rsp_seen;

   initial begin
      fail_count = 0;
      pending    = 0;
      rsp_seen   = 0;
   end

   function automatic int unsigned grid_index(int unsigned r, int unsigned c);
      return (r % ROWS) * COLS + (c % COLS);
   endfunction

   // Applies one transaction to the predicted grid and gives back the intensity it returns
   function automatic logic [VAL_W-1:0] apply_item(logic [FUNC_W-1:0] f,
                                                   logic [FIELD_W-1:0] col_in,
                                                   logic [FIELD_W-1:0] row_in,
                                                   logic [VAL_W-1:0] v);
      int unsigned c, r, left, right, sum;
      logic [VAL_W-1:0] res;
      c = col_in % COLS;
      r = row_in % ROWS;
      case (f)
         FUNC_WRITE: begin
            heat[grid_index(r, c)] = v;
            res = v;
         end
         FUNC_COMPUTE: begin
            left  = (c + COLS - 1) % COLS;
            right = (c + 1) % COLS;
            sum   = heat[grid_index(r + 1, left)] + heat[grid_index(r + 1, c)]
                  + heat[grid_index(r + 1, right)] + heat[grid_index(r + 2, c)];
            res   = VAL_W'((sum * HEAT_GAIN) / HEAT_DIV);
            heat[grid_index(r, c)] = res;
         end
         default: res = heat[grid_index(r, c)];   // read, and the spare code behaves as one
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (heat[i]) heat[i] = '0;
         intensity_q.delete();
      end else begin
         // response first: it can never belong to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (intensity_q.size() == 0) begin
               report_mismatch($sformatf("response %0d (intensity %0d) with nothing outstanding",
                                         rsp_seen, rsp_intensity));
            end else begin
               want = intensity_q.pop_front();
               if (rsp_intensity !== want)
                  report_mismatch($sformatf("response %0d: intensity %0d, predicted %0d",
                                            rsp_seen, rsp_intensity, want));
            end
            rsp_seen++;
         end
         if (req_valid && req_ready)
            intensity_q.push_back(apply_item(req_func, req_col, req_row, req_value));
      end
      pending = intensity_q.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the fire effect cell update block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
   import fecu_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int RESET_CYCLES  = 4;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_CYCLES  = 40;
   localparam int TIMEOUT_NS    = 5_000_000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [FUNC_W-1:0]   req_func;
   logic [FIELD_W-1:0]  req_col;
   logic [FIELD_W-1:0]  req_row;
   logic [VAL_W-1:0]    req_value;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [VAL_W-1:0]    rsp_intensity;

   int unsigned fail_count;
   int          pending;
   int          sent_count = 0;
   bit          no_gaps = 0;
   bit          hold_off_req = 0;

   fire_effect_cell_update_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_intensity (rsp_intensity)
   );

   fecu_grid_check grid_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_intensity (rsp_intensity),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offers one transaction and returns at the edge where it is taken
   task automatic send_item(input logic [FUNC_W-1:0] f, input int c, input int r, input int v);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_col   <= FIELD_W'(c);
      req_row   <= FIELD_W'(r);
      req_value <= VAL_W'(v);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Seed two rows under a small window, burn two rows upwards, read a little back
   task automatic fire_pass();
      int bc, br, k;
      bc = ($urandom_range(0, 3) == 0) ? 126 + $urandom_range(0, 2) : $urandom_range(0, 127);
      br = ($urandom_range(0, 3) == 0) ? 125 + $urandom_range(0, 4) : $urandom_range(0, 127);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (k = -1; k <= 4; k++) send_item(FUNC_WRITE, bc + k, br + 2, $urandom_range(0, 255));
      for (k = -1; k <= 4; k++) send_item(FUNC_WRITE, bc + k, br + 1, $urandom_range(0, 255));
      for (k = 0; k < 4; k++) send_item(FUNC_COMPUTE, bc + k, br, $urandom_range(0, 255));
      for (k = 0; k < 4; k++) send_item(FUNC_COMPUTE, bc + k, br - 1, $urandom_range(0, 255));
      repeat (2)
         send_item($urandom_range(0, 1) ? FUNC_READ : FUNC_SPARE, bc + $urandom_range(0, 3),
                   br - $urandom_range(0, 1), $urandom_range(0, 255));
   endtask

   initial begin : stimulus
      bit second_hold;
      second_hold = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_func  <= FUNC_WRITE;
      req_col   <= '0;
      req_row   <= '0;
      req_value <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full neighbourhood with left column wrap: 1020 gives the top value 253
      send_item(FUNC_WRITE, 127, 1, 255);
      send_item(FUNC_WRITE, 0, 1, 255);
      send_item(FUNC_WRITE, 1, 1, 255);
      send_item(FUNC_WRITE, 0, 2, 255);
      send_item(FUNC_COMPUTE, 0, 0, 0);
      // right column wrap and the two-below row wrapping to row 0
      send_item(FUNC_WRITE, 126, 127, 17);
      send_item(FUNC_WRITE, 127, 127, 100);
      send_item(FUNC_WRITE, 0, 127, 200);
      send_item(FUNC_WRITE, 127, 0, 55);
      send_item(FUNC_COMPUTE, 127, 126, 0);
      // bottom row: both neighbour rows wrap
      send_item(FUNC_WRITE, 5, 0, 128);
      send_item(FUNC_COMPUTE, 5, 127, 0);
      send_item(FUNC_READ, 0, 0, 0);
      send_item(FUNC_SPARE, 127, 126, 0);
      send_item(FUNC_WRITE, 0, 0, 0);
      send_item(FUNC_READ, 0, 0, 255);
      send_item(FUNC_COMPUTE, 64, 64, 255);
      send_item(FUNC_WRITE, 127, 127, 255);
      send_item(FUNC_READ, 127, 127, 8'hAA);
      send_item(FUNC_SPARE, 0, 0, 8'h55);

      hold_off_req = 1;
      while (sent_count < RANDOM_ITEMS) begin
         if (!second_hold && sent_count > RANDOM_ITEMS / 2) begin
            hold_off_req = 1;
            second_hold  = 1;
         end
         if ($urandom_range(0, 9) < 7) begin
            fire_pass();
         end else begin
            no_gaps = 0;
            repeat (8)
               send_item(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 127),
                         $urandom_range(0, 127), $urandom_range(0, 255));
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("fire_effect_cell_update_core: match");
      else
         $display("fire_effect_cell_update_core: mismatch");
      $finish;
   end

   initial begin : rsp_side
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 4);
         // long hold-off so the block fills up and drops req_ready
         if (hold_off_req) begin
            hold_off_req = 0;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("fire_effect_cell_update_core: mismatch");
      $finish;
   end

endmodule

// ----- fire_effect_cell_update_core.f -----
rtl/fecu_pkg.sv
rtl/fecu_front.sv
rtl/fecu_queue.sv
rtl/fecu_back.sv
rtl/fire_effect_cell_update_core.sv
rtl/fecu_checker.sv
tb/sv/fecu_grid_check.sv
tb/sv/tb_top.sv
